// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, sampled on clock, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// types, codes and sizes shared by the retransmit tracking table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int ENTRIES     = 16;
   localparam int MAX_RESULTS = 16;
   localparam int SLOT_W      = 4;
   localparam int ENTRY_W     = 4;
   localparam int ATT_W       = 8;
   localparam int CD_W        = 16;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // register indexes on the csr port
   localparam int REG_ATTEMPT_LIMIT  = 0;
   localparam int REG_RETRY_INTERVAL = 1;

   localparam logic [ATT_W-1:0] ATTEMPT_LIMIT_RST  = ATT_W'(3);
   localparam logic [CD_W-1:0]  RETRY_INTERVAL_RST = CD_W'(10);

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_ACK   = 2'd1,
      OP_TICK  = 2'd2,
      OP_RETRY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      EV_SENT       = 3'd0,
      EV_DELIVERED  = 3'd1,
      EV_FAILED     = 3'd2,
      EV_RETRANSMIT = 3'd3,
      EV_RESEND     = 3'd4,
      EV_FULL       = 3'd5
   } ev_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   typedef struct packed {
      logic              occupied;
      logic              failed;
      logic [ATT_W-1:0]  attempts;
      logic [CD_W-1:0]   countdown;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic              slot_hit;
      logic              found;
      logic [ATT_W-1:0]  limit;
      logic [CD_W-1:0]   interval;
   } head_ctl_type;

   typedef struct packed {
      logic   valid;
      ev_type code;
   } head_evt_type;

endpackage

// File: hw/rtl/rtt_cell.sv
// ----------------------------------------------------------------------------
// rtt_cell
// one table entry of the rotating ring, takes its neighbor's entry on shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_cell
   import rtt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type din,
   output entry_type dout
);

   logic             occupied_ff;
   logic             failed_ff;
   logic [ATT_W-1:0] attempts_ff;
   logic [CD_W-1:0]  countdown_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
         failed_ff   <= 1'b0;
      end else if (shift_en) begin
         occupied_ff <= din.occupied;
         failed_ff   <= din.failed;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         attempts_ff  <= din.attempts;
         countdown_ff <= din.countdown;
      end
   end

   assign dout = '{occupied: occupied_ff, failed: failed_ff,
                   attempts: attempts_ff, countdown: countdown_ff};

endmodule

// File: hw/rtl/rtt_head.sv
// ----------------------------------------------------------------------------
// rtt_head
// update of the entry at the head of the ring for the request being walked
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtt_head
   import rtt_pkg::*;
(
   input  head_ctl_type ctl,
   input  entry_type    cur,
   output entry_type    nxt,
   output head_evt_type evt
);

   logic [CD_W-1:0] cd_dec;

   // saturating decrement
   assign cd_dec = (cur.countdown == '0) ? '0 : cur.countdown - CD_W'(1);

   always_comb begin
      nxt       = cur;
      evt.valid = 1'b0;
      evt.code  = EV_SENT;
      case (ctl.op)
         OP_SEND: begin
            if (!ctl.found && !cur.occupied) begin
               nxt.occupied  = 1'b1;
               nxt.failed    = 1'b0;
               nxt.attempts  = ATT_W'(1);
               nxt.countdown = ctl.interval;
               evt.valid     = 1'b1;
               evt.code      = EV_SENT;
            end
         end
         OP_ACK: begin
            if (ctl.slot_hit && cur.occupied) begin
               nxt.occupied = 1'b0;
               nxt.failed   = 1'b0;
               evt.valid    = 1'b1;
               evt.code     = EV_DELIVERED;
            end
         end
         OP_TICK: begin
            if (cur.occupied && !cur.failed) begin
               if (cd_dec != '0) begin
                  nxt.countdown = cd_dec;
               end else if (cur.attempts >= ctl.limit) begin
                  nxt.countdown = cd_dec;
                  nxt.failed    = 1'b1;
                  evt.valid     = 1'b1;
                  evt.code      = EV_FAILED;
               end else begin
                  nxt.attempts  = cur.attempts + ATT_W'(1);
                  nxt.countdown = ctl.interval;
                  evt.valid     = 1'b1;
                  evt.code      = EV_RETRANSMIT;
               end
            end
         end
         OP_RETRY: begin
            if (ctl.slot_hit && cur.occupied) begin
               nxt.occupied  = 1'b1;
               nxt.failed    = 1'b0;
               nxt.attempts  = ATT_W'(1);
               nxt.countdown = ctl.interval;
               evt.valid     = 1'b1;
               evt.code      = EV_RESEND;
            end
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/retransmit_tracking_table_unit.sv
// ----------------------------------------------------------------------------
// retransmit_tracking_table_unit
// table of outstanding messages with ack, retry countdown and failure marking
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// req       in         req_tvalid / req_tready     tuser operation, tdata slot
// rsp       out        rsp_tvalid / rsp_tready     tdata entry, tuser event_res; tlast
// csr       in         psel/penable/pwrite/pready  attempt_limit, retry_interval
//
// a request holds the unit through ST_WALK and ST_FLUSH after its acceptance,
// so no new request is taken until it is done, longer with rsp stalls: the
// ring rotates one cell per cycle past the head update unit unless held, then
// ST_FLUSH closes it and marks any last response. req_tready is idle only.
// the ring holds while a new response cannot be buffered.
// reset clears the occupied and failed bits of every cell at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module retransmit_tracking_table_unit
   import rtt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] slot, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] entry, [7:4] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [ATT_W-1:0] limit_ff, limit_in;
   logic [CD_W-1:0]  interval_ff, interval_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      limit_in    = limit_ff;
      interval_in = interval_ff;
      csr_prdata  = '0;
      unique case (csr_paddr[2])
         1'(REG_ATTEMPT_LIMIT): begin
            csr_prdata = 32'(limit_ff);
            if (csr_wr) limit_in = csr_pwdata[ATT_W-1:0];
         end
         1'(REG_RETRY_INTERVAL): begin
            csr_prdata = 32'(interval_ff);
            if (csr_wr) interval_in = csr_pwdata[CD_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= ATTEMPT_LIMIT_RST;
         interval_ff <= RETRY_INTERVAL_RST;
      end else begin
         limit_ff    <= limit_in;
         interval_ff <= interval_in;
      end
   end

   // control state
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                found_ff, found_in;
   op_type              op_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic                pend_valid_ff, pend_valid_in;
   logic [ENTRY_W-1:0]  pend_entry_ff, pend_entry_in;
   ev_type              pend_ev_ff, pend_ev_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]  rsp_entry_ff, rsp_entry_in;
   ev_type              rsp_ev_ff, rsp_ev_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_acc;
   logic                advance;
   logic                out_free;
   logic                emit;

   // entry ring
   entry_type    ring_q   [ENTRIES];
   entry_type    cell_din [ENTRIES];
   entry_type    head_nxt;
   head_ctl_type head_ctl;
   head_evt_type head_evt;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      if (k == ENTRIES - 1) begin : g_tail
         assign cell_din[k] = head_nxt;
      end else begin : g_body
         assign cell_din[k] = ring_q[k+1];
      end
      rtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (advance),
         .din      (cell_din[k]),
         .dout     (ring_q[k])
      );
   end

   assign head_ctl = '{op: op_ff,
                       slot_hit: (32'(idx_ff) == 32'(slot_ff)),
                       found: found_ff,
                       limit: limit_ff,
                       interval: interval_ff};

   rtt_head u_head (
      .ctl (head_ctl),
      .cur (ring_q[0]),
      .nxt (head_nxt),
      .evt (head_evt)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = head_evt.valid && (cnt_ff < CNT_W'(MAX_RESULTS));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      advance       = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_entry_in = pend_entry_ff;
      pend_ev_in    = pend_ev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_WALK;
               idx_in   = '0;
               cnt_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_WALK: begin
            // a second event needs the held one moved out first
            if (!(emit && pend_valid_ff && !out_free)) begin
               advance = 1'b1;
               if (op_ff == OP_SEND && head_evt.valid) found_in = 1'b1;
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_entry_in = pend_entry_ff;
                     rsp_ev_in    = pend_ev_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_entry_in = ENTRY_W'(idx_ff);
                  pend_ev_in    = head_evt.code;
                  cnt_in        = cnt_ff + CNT_W'(1);
               end
               if (idx_ff == IDX_W'(ENTRIES - 1)) begin
                  idx_in   = '0;
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = pend_entry_ff;
                  rsp_ev_in     = pend_ev_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (op_ff == OP_SEND && !found_ff) begin
               // no free slot anywhere
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_entry_in = '0;
                  rsp_ev_in    = EV_FULL;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff   <= op_type'(req_tuser[1:0]);
         slot_ff <= req_tdata[SLOT_W-1:0];
      end
      pend_entry_ff <= pend_entry_in;
      pend_ev_ff    <= pend_ev_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_entry_ff};
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPLIES(a_idle_no_pend, state_ff == ST_IDLE, !pend_valid_ff)
   `ASSERT_IMPLIES(a_idle_ring_aligned, state_ff == ST_IDLE, idx_ff == '0)
   `ASSERT_NEXT(a_req_starts_walk, req_acc, state_ff == ST_WALK)
   `ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_RESULTS))

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for retransmit_tracking_table_unit: a queue-fed request
// driver, a response monitor and a request-level table predictor, run through
// several timing settings with random stalls on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import rtt_pkg::*;
();

   localparam int SETTLE_CYCLES      = 2 * (ENTRIES + 1) + 4;
   localparam int RSP_HOLD_CYCLES    = 300;

   typedef struct {
      op_type             op;
      logic [SLOT_W-1:0]  slot;
   } table_request_type;

   typedef struct {
      logic [ENTRY_W-1:0] entry;
      ev_type             code;
      logic               last;
   } table_event_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;

   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [3:0] slot, [7:4] zero
   logic [1:0]  req_tuser   = '0;   // [1:0] operation

   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [3:0] entry, [7:4] zero
   logic [2:0]  rsp_tuser;          // [2:0] event_res
   logic        rsp_tlast;

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // table mirror and its register copy
   logic              tbl_occ  [ENTRIES] = '{default: 1'b0};
   logic              tbl_fail [ENTRIES] = '{default: 1'b0};
   logic [ATT_W-1:0]  tbl_att  [ENTRIES] = '{default: '0};
   logic [CD_W-1:0]   tbl_cd   [ENTRIES] = '{default: '0};
   logic [ATT_W-1:0]  cfg_limit    = ATTEMPT_LIMIT_RST;
   logic [CD_W-1:0]   cfg_interval = RETRY_INTERVAL_RST;

   table_request_type pending_requests [$];
   table_event_type   expected_events  [$];
   logic [ENTRIES-1:0] gen_occ = '0;   // occupancy as seen by the request generator

   int   fail_count = 0;
   logic idle_on    = 1'b1;
   logic hold_pulse = 1'b0;
   int   hold_left  = 0;
   int   send_gap   = 0;
   int   rcv_gap    = 0;

   retransmit_tracking_table_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic void arm_entry(input int idx);
      tbl_occ[idx]  = 1'b1;
      tbl_fail[idx] = 1'b0;
      tbl_att[idx]  = ATT_W'(1);
      tbl_cd[idx]   = cfg_interval;
   endfunction

   function automatic table_event_type make_event(input int idx, input ev_type code);
      table_event_type ev;
      ev.entry = ENTRY_W'(idx);
      ev.code  = code;
      ev.last  = 1'b0;
      return ev;
   endfunction

   // applies one accepted request to the mirror and queues the events it causes
   function automatic void predict_table_update(input op_type op,
                                                input logic [SLOT_W-1:0] slot);
      table_event_type evs [$];
      int              idx;
      ev_type          code;
      idx = -1;
      case (op)
         OP_SEND: begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
               if (!tbl_occ[i]) idx = i;
            end
            if (idx >= 0) begin
               arm_entry(idx);
               evs.insert(evs.size(), make_event(idx, EV_SENT));
            end else begin
               evs.insert(evs.size(), make_event(0, EV_FULL));
            end
         end
         OP_ACK: begin
            if (int'(slot) < ENTRIES && tbl_occ[slot]) begin
               tbl_occ[slot]  = 1'b0;
               tbl_fail[slot] = 1'b0;
               evs.insert(evs.size(), make_event(int'(slot), EV_DELIVERED));
            end
         end
         OP_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_occ[i] && !tbl_fail[i]) begin
                  if (tbl_cd[i] != 0) tbl_cd[i] = tbl_cd[i] - 1'b1;
                  if (tbl_cd[i] == 0) begin
                     if (tbl_att[i] >= cfg_limit) begin
                        tbl_fail[i] = 1'b1;
                        code = EV_FAILED;
                     end else begin
                        tbl_att[i] = tbl_att[i] + 1'b1;
                        tbl_cd[i]  = cfg_interval;
                        code = EV_RETRANSMIT;
                     end
                     if (evs.size() < MAX_RESULTS)
                        evs.insert(evs.size(), make_event(i, code));
                  end
               end
            end
         end
         default: begin
            if (int'(slot) < ENTRIES && tbl_occ[slot]) begin
               arm_entry(int'(slot));
               evs.insert(evs.size(), make_event(int'(slot), EV_RESEND));
            end
         end
      endcase
      if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[k]) expected_events.insert(expected_events.size(), evs[k]);
   endfunction

   function automatic void queue_request(input op_type op, input logic [SLOT_W-1:0] slot);
      int                idx;
      table_request_type rq;
      idx     = -1;
      rq.op   = op;
      rq.slot = slot;
      pending_requests.insert(pending_requests.size(), rq);
      if (op == OP_SEND) begin
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!gen_occ[i]) idx = i;
         end
         if (idx >= 0) gen_occ[idx] = 1'b1;
      end else if (op == OP_ACK && int'(slot) < ENTRIES) begin
         gen_occ[slot] = 1'b0;
      end
   endfunction

   // random sends, acks, ticks and retries; acks and retries mostly aim at live slots, some at random slots
   function automatic void queue_random_requests(input int count);
      int                r;
      op_type            op;
      logic [SLOT_W-1:0] slot;
      for (int n = 0; n < count; n++) begin
         r    = $urandom_range(0, 99);
         slot = SLOT_W'($urandom_range(0, 15));
         if (r < 30)      op = OP_SEND;
         else if (r < 52) op = OP_ACK;
         else if (r < 85) op = OP_TICK;
         else             op = OP_RETRY;
         if ((op == OP_ACK || op == OP_RETRY) && gen_occ != '0
             && $urandom_range(0, 9) != 0) begin
            while (!gen_occ[slot]) slot = SLOT_W'($urandom_range(0, 15));
         end
         queue_request(op, slot);
      end
   endfunction

   task automatic csr_write(input int index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * index);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_config(input logic [ATT_W-1:0] limit,
                               input logic [CD_W-1:0] interval);
      csr_write(REG_ATTEMPT_LIMIT, 32'(limit));
      csr_write(REG_RETRY_INTERVAL, 32'(interval));
      cfg_limit    = limit;
      cfg_interval = interval;
   endtask

   // a request with no response may still be in the ring, so linger afterwards
   task automatic wait_table_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      table_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_table_update(op_type'(req_tuser), req_tdata[SLOT_W-1:0]);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= {4'b0, nxt.slot};
               if (idle_on && hold_left == 0 && $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_pulse) hold_left <= RSP_HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin : check_responses
      table_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rcv_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected response: entry %0d event_res %0d last %0b",
                      rsp_tdata[3:0], rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[3:0] !== want.entry) begin
                  $error("entry: expected %0d, actual %0d", want.entry, rsp_tdata[3:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.code) begin
                  $error("event_res: expected %0d, actual %0d", want.code, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rcv_gap != 0) begin
            rcv_gap    <= rcv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rcv_gap    <= $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values of both registers
      queue_random_requests(40);
      wait_table_idle();

      // empty the table for the directed part
      for (int i = 0; i < ENTRIES; i++) begin
         if (gen_occ[i]) queue_request(OP_ACK, SLOT_W'(i));
      end
      wait_table_idle();

      write_config(8'd1, 16'd1);
      queue_request(OP_TICK, 4'd0);                 // nothing to expire
      queue_request(OP_ACK, 4'd15);                 // empty slot
      queue_request(OP_RETRY, 4'd0);                // empty slot
      for (int i = 0; i < ENTRIES; i++) queue_request(OP_SEND, SLOT_W'(i));
      queue_request(OP_SEND, 4'd15);                // table full
      queue_request(OP_RETRY, 4'd15);               // retry of a waiting entry
      queue_request(OP_TICK, 4'd15);                // every entry fails at once
      queue_request(OP_ACK, 4'd3);                  // ack of a failed entry
      queue_request(OP_RETRY, 4'd0);                // retry of a failed entry
      queue_request(OP_TICK, 4'd9);
      queue_request(OP_SEND, 4'd0);                 // refills the freed slot
      wait_table_idle();

      write_config(8'd255, 16'd65535);
      queue_random_requests(25);
      wait_table_idle();

      write_config(8'd2, 16'd3);
      queue_random_requests(60);
      // long response stall while requests keep coming
      hold_pulse <= 1'b1;
      @(posedge clock);
      hold_pulse <= 1'b0;
      wait_table_idle();

      // zero interval and zero limit
      write_config(8'd0, 16'd0);
      queue_random_requests(25);
      wait_table_idle();

      idle_on <= 1'b0;
      write_config(8'd6, 16'd2);
      queue_random_requests(60);
      wait_table_idle();

      if (expected_events.size() != 0) begin
         $error("%0d expected responses never arrived", expected_events.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_cell.sv
hw/rtl/rtt_head.sv
hw/rtl/retransmit_tracking_table_unit.sv
tb/tb.sv
